// File: hdl/cta_pkg.sv
// Shared types and constants for the change-triggered averaged capture block.
package cta_pkg;

    // Capture capacity default, in points
    localparam int DEPTH_DEFAULT = 4096;

    // Field widths
    localparam int SAMPLE_W = 16;
    localparam int SUM_W    = 32;
    localparam int INDEX_W  = 12;
    localparam int CFG_IDX_W = 2;

    // Serial divide: one quotient bit per cycle over the whole sum
    localparam int DIV_STEPS = SUM_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // Input operation codes
    localparam logic OP_SAMPLE  = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_AVG_COUNT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHANGE_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_POST_COUNT   = 2'd2;

    // Control sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_PUSH
    } cta_state_t;

endpackage

// File: hdl/change_triggered_averaged_capture.sv
// Top level of the change-triggered averaged capture block.

// Raw samples are summed until avg_count of them (0 counts as 1) make one point;
// the point value is the sum divided by the sample count, produced by a bit-serial
// restoring divider that yields one quotient bit per cycle. A sample that does not
// complete a point, a restart, or a sample after the capture has ended is simply
// accepted in the idle state. A sample that completes a point is accepted, then
// 32 divide steps run over the 32-bit sum, then the point waits until the output
// register is free and is loaded into it. The result sits in an output register, so the next
// sample is taken while a finished point still waits for out_ready. Point 0 is
// the reference; the first later point farther from it than change_limit sets
// detected, and the capture then ends post_count points later, or at DEPTH points.
module change_triggered_averaged_capture #(
    parameter int DEPTH = cta_pkg::DEPTH_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration writes
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [cta_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cta_pkg::SAMPLE_W-1:0]   cfg_data,
    // sample items
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           op,
    input  logic [cta_pkg::SAMPLE_W-1:0]   sample,
    // point items
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [cta_pkg::SAMPLE_W-1:0]   point_value,
    output logic [cta_pkg::INDEX_W-1:0]    point_index,
    output logic                           detected,
    output logic                           last
);
    import cta_pkg::*;

    // Position counter holds 0..DEPTH
    localparam int IDX_W = $clog2(DEPTH + 1);
    // Trigger cap: position + 1 + post_count
    localparam int CAP_W = ((IDX_W > SAMPLE_W) ? IDX_W : SAMPLE_W) + 1;

    // Configuration registers
    logic [SAMPLE_W-1:0] avg_count_reg;
    logic [SAMPLE_W-1:0] change_limit_reg;
    logic [SAMPLE_W-1:0] post_count_reg;

    // Capture state
    logic [SUM_W-1:0]    acc_sum_reg;
    logic [SAMPLE_W-1:0] raw_in_point_reg;
    logic [IDX_W-1:0]    next_index_reg;
    logic [SAMPLE_W-1:0] reference_reg;
    logic                triggered_reg;
    logic [IDX_W-1:0]    end_index_reg;
    logic                done_reg;

    // Divider
    logic [SUM_W-1:0]     quot_reg;
    logic [SAMPLE_W-1:0]  rem_reg;
    logic [SAMPLE_W-1:0]  divisor_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;

    // Output register
    logic                out_valid_reg;
    logic [SAMPLE_W-1:0] out_value_reg;
    logic [INDEX_W-1:0]  out_index_reg;
    logic                out_detected_reg;
    logic                out_last_reg;

    cta_state_t state_reg, state_next;

    // Control decodes
    logic in_fire;
    logic take_sample;
    logic point_done;
    logic div_last;
    logic out_free;
    logic div_step;
    logic push;

    // Accumulate path
    logic [SUM_W-1:0]    acc_next;
    logic [SAMPLE_W-1:0] raw_next;
    logic [SAMPLE_W-1:0] need;

    // Divide step
    logic [SAMPLE_W:0] rem_shift;
    logic              rem_ge;
    logic [SAMPLE_W:0] rem_diff;

    // Point finish path
    logic [SAMPLE_W-1:0] point_val;
    logic [SAMPLE_W-1:0] abs_diff;
    logic                trig_now;
    logic [CAP_W-1:0]    cap;
    logic [IDX_W-1:0]    end_new;
    logic [IDX_W:0]      idx_plus;
    logic                is_last;
    logic [IDX_W+INDEX_W-1:0] idx_ext;

    assign cfg_ready = 1'b1;

    // Sample accumulate and point completion check
    assign acc_next   = acc_sum_reg + SUM_W'(sample);
    assign raw_next   = raw_in_point_reg + SAMPLE_W'(1);
    assign need       = (avg_count_reg == '0) ? SAMPLE_W'(1) : avg_count_reg;
    assign in_fire    = in_valid && in_ready;
    assign take_sample = in_fire && (op == OP_SAMPLE) && !done_reg;
    assign point_done = raw_next >= need;

    // Restoring divide step
    assign rem_shift = {rem_reg, quot_reg[SUM_W-1]};
    assign rem_ge    = rem_shift >= {1'b0, divisor_reg};
    assign rem_diff  = rem_shift - {1'b0, divisor_reg};
    assign div_last  = div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1);

    // Point value, clamped to 16 bits
    assign point_val = (quot_reg[SUM_W-1:SAMPLE_W] != '0) ? {SAMPLE_W{1'b1}}
                                                          : quot_reg[SAMPLE_W-1:0];

    // Change detection against the reference
    assign abs_diff = (point_val > reference_reg) ? point_val - reference_reg
                                                  : reference_reg - point_val;
    assign trig_now = (next_index_reg != '0) && !triggered_reg
                      && (abs_diff > change_limit_reg);
    assign cap      = CAP_W'(next_index_reg) + CAP_W'(1) + CAP_W'(post_count_reg);
    assign end_new  = !trig_now ? end_index_reg
                    : (cap < CAP_W'(DEPTH)) ? cap[IDX_W-1:0] : IDX_W'(DEPTH);
    assign idx_plus = {1'b0, next_index_reg} + (IDX_W+1)'(1);
    assign is_last  = idx_plus >= {1'b0, end_new};
    assign idx_ext  = {{INDEX_W{1'b0}}, next_index_reg};

    assign out_free = !out_valid_reg || out_ready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (take_sample && point_done)
                    state_next = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                if (div_last)
                    state_next = ST_PUSH;
            end
            ST_PUSH:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // State outputs
    always_comb
    begin
        in_ready = 1'b0;
        div_step = 1'b0;
        push     = 1'b0;
        case (state_reg)
            ST_IDLE:   in_ready = 1'b1;
            ST_DIVIDE: div_step = 1'b1;
            ST_PUSH:   push     = out_free;
            default:   in_ready = 1'b0;
        endcase
    end

    // Control and capture state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            avg_count_reg    <= SAMPLE_W'(1);
            change_limit_reg <= '0;
            post_count_reg   <= '0;
            acc_sum_reg      <= '0;
            raw_in_point_reg <= '0;
            next_index_reg   <= '0;
            reference_reg    <= '0;
            triggered_reg    <= 1'b0;
            end_index_reg    <= IDX_W'(DEPTH);
            done_reg         <= 1'b0;
            div_cnt_reg      <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // register writes
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_AVG_COUNT:    avg_count_reg    <= cfg_data;
                    REG_CHANGE_LIMIT: change_limit_reg <= cfg_data;
                    REG_POST_COUNT:   post_count_reg   <= cfg_data;
                    default:          ;
                endcase
            end

            // restart or sample accumulate
            if (in_fire && (op == OP_RESTART))
            begin
                acc_sum_reg      <= '0;
                raw_in_point_reg <= '0;
                next_index_reg   <= '0;
                reference_reg    <= '0;
                triggered_reg    <= 1'b0;
                end_index_reg    <= IDX_W'(DEPTH);
                done_reg         <= 1'b0;
            end
            else if (take_sample)
            begin
                if (point_done)
                begin
                    acc_sum_reg      <= '0;
                    raw_in_point_reg <= '0;
                end
                else
                begin
                    acc_sum_reg      <= acc_next;
                    raw_in_point_reg <= raw_next;
                end
            end

            // divide step counter
            if (take_sample && point_done)
                div_cnt_reg <= '0;
            else if (div_step)
                div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);

            // point finish: reference, trigger and end of capture
            if (push)
            begin
                if (next_index_reg == '0)
                    reference_reg <= point_val;
                triggered_reg  <= triggered_reg || trig_now;
                end_index_reg  <= end_new;
                next_index_reg <= idx_plus[IDX_W-1:0];
                if (is_last)
                    done_reg <= 1'b1;
            end

            // output handshake
            if (push)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Divider datapath
    always_ff @(posedge clk)
    begin
        if (take_sample && point_done)
        begin
            quot_reg    <= acc_next;
            rem_reg     <= '0;
            divisor_reg <= raw_next;
        end
        else if (div_step)
        begin
            quot_reg <= {quot_reg[SUM_W-2:0], rem_ge};
            rem_reg  <= rem_ge ? rem_diff[SAMPLE_W-1:0] : rem_shift[SAMPLE_W-1:0];
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            out_value_reg    <= point_val;
            out_index_reg    <= idx_ext[INDEX_W-1:0];
            out_detected_reg <= triggered_reg || trig_now;
            out_last_reg     <= is_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign point_value = out_value_reg;
    assign point_index = out_index_reg;
    assign detected    = out_detected_reg;
    assign last        = out_last_reg;

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the change-triggered averaged capture block.
module tb;
    import cta_pkg::*;

    // Capture capacity used by the block under test
    localparam int CAP_DEPTH = DEPTH_DEFAULT;
    // Cycles to let a point in the divider settle before a register write
    localparam int SETTLE_CYCLES = 40;
    // Run is roughly 1.2k items; allow well over the time they need
    localparam int unsigned RUN_LIMIT = 5_000_000;
    localparam int RANDOM_ITEMS = 1120;

    typedef struct packed {
        logic [SAMPLE_W-1:0] value;
        logic [INDEX_W-1:0]  index;
        logic                detected;
        logic                last;
    } point_t;

    // Tracks capture state, predicts each point and checks what comes out
    class capture_tracker;
        int unsigned         depth;
        logic [SAMPLE_W-1:0] avg_count;
        logic [SAMPLE_W-1:0] change_limit;
        logic [SAMPLE_W-1:0] post_count;
        logic [SUM_W-1:0]    acc_sum;
        logic [SAMPLE_W-1:0] raw_in_point;
        logic [SAMPLE_W-1:0] ref_value;
        int unsigned         next_index;
        int unsigned         end_index;
        bit                  has_triggered;
        bit                  capture_done;
        point_t              pending_points[$];
        int                  errors;

        function new(int unsigned cap_depth);
            depth        = cap_depth;
            avg_count    = SAMPLE_W'(1);
            change_limit = '0;
            post_count   = '0;
            errors       = 0;
            restart_capture();
        endfunction

        function void restart_capture();
            acc_sum       = 0;
            raw_in_point  = 0;
            ref_value     = 0;
            next_index    = 0;
            end_index     = depth;
            has_triggered = 0;
            capture_done  = 0;
        endfunction

        function void write_setting(logic [CFG_IDX_W-1:0] idx, logic [SAMPLE_W-1:0] data);
            case (idx)
                REG_AVG_COUNT:    avg_count = data;
                REG_CHANGE_LIMIT: change_limit = data;
                REG_POST_COUNT:   post_count = data;
                default: ;
            endcase
        endfunction

        // Accepted input item: update state, queue a point if one completes
        function void note_item(logic op_code, logic [SAMPLE_W-1:0] value_in);
            logic [SAMPLE_W-1:0] need;
            logic [SUM_W-1:0]    quotient;
            logic [SAMPLE_W-1:0] value;
            logic [SAMPLE_W-1:0] diff;
            int unsigned         cap_index;
            int unsigned         idx;
            point_t              pt;
            if (op_code == OP_RESTART)
            begin
                restart_capture();
                return;
            end
            if (capture_done)
                return;
            acc_sum += value_in;
            raw_in_point += 1;
            need = (avg_count == 0) ? 16'd1 : avg_count;
            if (raw_in_point < need)
                return;

            // divisor is the count actually gathered (avg_count may have dropped)
            quotient = (raw_in_point == 0) ? '0 : acc_sum / raw_in_point;
            value = (quotient > 32'hFFFF) ? 16'hFFFF : quotient[SAMPLE_W-1:0];
            acc_sum = 0;
            raw_in_point = 0;

            idx = next_index;
            if (idx == 0)
                ref_value = value;
            else if (!has_triggered)
            begin
                diff = (value > ref_value) ? value - ref_value : ref_value - value;
                if (diff > change_limit)
                begin
                    has_triggered = 1;
                    cap_index = idx + 1 + post_count;
                    end_index = (cap_index < depth) ? cap_index : depth;
                end
            end

            pt.value    = value;
            pt.index    = idx[INDEX_W-1:0];
            pt.detected = has_triggered;
            pt.last     = (idx + 1 >= end_index);
            if (pt.last)
                capture_done = 1;
            next_index = idx + 1;
            pending_points.push_back(pt);
        endfunction

        function int pending();
            return pending_points.size();
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 100)
                $display("mismatch: %s", msg);
        endtask

        task check_point(point_t got);
            point_t want;
            if (pending_points.size() == 0)
            begin
                report($sformatf("unexpected point value %h index %0d", got.value, got.index));
                return;
            end
            want = pending_points.pop_front();
            if (got.value !== want.value)
                report($sformatf("point %0d value %h, expected %h",
                                 want.index, got.value, want.value));
            if (got.index !== want.index)
                report($sformatf("point index %0d, expected %0d", got.index, want.index));
            if (got.detected !== want.detected)
                report($sformatf("point %0d detected %b, expected %b",
                                 want.index, got.detected, want.detected));
            if (got.last !== want.last)
                report($sformatf("point %0d last %b, expected %b",
                                 want.index, got.last, want.last));
        endtask
    endclass

    logic                 clk = 0;
    logic                 rst_n = 0;
    logic                 cfg_valid = 0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [SAMPLE_W-1:0]  cfg_data = '0;
    logic                 in_valid = 0;
    logic                 in_ready;
    logic                 in_op = OP_SAMPLE;
    logic [SAMPLE_W-1:0]  in_sample = '0;
    logic                 out_valid;
    logic                 out_ready = 0;
    logic [SAMPLE_W-1:0]  point_value;
    logic [INDEX_W-1:0]   point_index;
    logic                 detected;
    logic                 last;

    int                   tx_gap_pct = 0;
    int                   rx_stall_pct = 0;
    int                   rx_stall_left = 0;
    int unsigned          cycle_count = 0;
    capture_tracker       tracker;

    change_triggered_averaged_capture #(
        .DEPTH(CAP_DEPTH)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .op         (in_op),
        .sample     (in_sample),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .point_value(point_value),
        .point_index(point_index),
        .detected   (detected),
        .last       (last)
    );

    always #4 clk = ~clk;

    // Idle length: mostly short, now and then long
    function automatic int idle_len();
        if ($urandom_range(0, 99) < 88)
            return $urandom_range(1, 3);
        return $urandom_range(12, 80);
    endfunction

    function automatic int next_gap();
        if ($urandom_range(0, 99) < tx_gap_pct)
            return idle_len();
        return 0;
    endfunction

    // Random value over the full ADC range
    function automatic logic [SAMPLE_W-1:0] any_value();
        return SAMPLE_W'($urandom_range(0, 65535));
    endfunction

    // Sample scattered around a base value, clamped to the ADC range
    function automatic logic [SAMPLE_W-1:0] near_value(input int base, input int spread);
        int v;
        v = base + $urandom_range(0, 2 * spread) - spread;
        if (v < 0)
            v = 0;
        if (v > 65535)
            v = 65535;
        return v[SAMPLE_W-1:0];
    endfunction

    // Receiver side: random stalls on out_ready
    always @(negedge clk)
    begin
        if (rx_stall_left > 0)
        begin
            out_ready = 0;
            rx_stall_left--;
        end
        else if ($urandom_range(0, 99) < rx_stall_pct)
        begin
            out_ready = 0;
            rx_stall_left = idle_len() - 1;
        end
        else
            out_ready = 1;
    end

    // Result monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_ready)
            tracker.check_point({point_value, point_index, detected, last});
    end

    // Watchdog
    initial
    begin
        while (cycle_count < RUN_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d points outstanding",
                 cycle_count, tracker.pending());
        $display("** change_triggered_averaged_capture: FAILED **");
        $finish;
    end

    // One input item; returns at the falling edge after acceptance, valid still high
    task send_item(input logic op_code, input logic [SAMPLE_W-1:0] value_in, input int gap);
        if (gap > 0)
        begin
            in_valid = 0;
            repeat (gap) @(negedge clk);
        end
        in_valid  = 1;
        in_op     = op_code;
        in_sample = value_in;
        do
            @(posedge clk);
        while (!in_ready);
        tracker.note_item(op_code, value_in);
        @(negedge clk);
    endtask

    // Hold off input until every predicted point has come out
    task drain();
        in_valid = 0;
        while (tracker.pending() != 0)
            @(negedge clk);
    endtask

    // Register write with the block idle
    task write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SAMPLE_W-1:0] data);
        drain();
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_valid = 1;
        cfg_index = idx;
        cfg_data  = data;
        do
            @(posedge clk);
        while (!cfg_ready);
        tracker.write_setting(idx, data);
        @(negedge clk);
        cfg_valid = 0;
    endtask

    task write_config(input logic [SAMPLE_W-1:0] avg, input logic [SAMPLE_W-1:0] limit,
                      input logic [SAMPLE_W-1:0] post);
        write_reg(REG_AVG_COUNT, avg);
        write_reg(REG_CHANGE_LIMIT, limit);
        write_reg(REG_POST_COUNT, post);
    endtask

    initial
    begin
        int                  items;
        int                  n;
        int                  k;
        int                  base;
        int                  spread;
        int                  r;
        int                  avg;
        int                  limit;
        int                  post;
        bit                  mid_change;
        logic [SAMPLE_W-1:0] value_in;

        tracker = new(CAP_DEPTH);
        repeat (12) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // Directed: reset settings, immediate trigger with zero post count
        tx_gap_pct   = 20;
        rx_stall_pct = 20;
        send_item(OP_SAMPLE, 16'h0000, next_gap());
        send_item(OP_SAMPLE, 16'h0000, next_gap());
        send_item(OP_SAMPLE, 16'hFFFF, next_gap());
        send_item(OP_SAMPLE, 16'h1234, next_gap());   // after last point: ignored
        send_item(OP_RESTART, 16'hFFFF, next_gap());

        // Zero average count acts as one; full-scale change equals the limit
        write_config(16'd0, 16'hFFFF, 16'hFFFF);
        send_item(OP_SAMPLE, 16'hFFFF, next_gap());
        send_item(OP_SAMPLE, 16'h0000, next_gap());
        send_item(OP_SAMPLE, 16'hAAAA, next_gap());
        send_item(OP_SAMPLE, 16'h5555, next_gap());
        send_item(OP_RESTART, 16'h0000, next_gap());

        // Averaging of full-scale samples, then average count changed mid-point
        write_reg(REG_AVG_COUNT, 16'd4);
        repeat (4) send_item(OP_SAMPLE, 16'hFFFF, next_gap());
        send_item(OP_SAMPLE, 16'h0001, next_gap());
        send_item(OP_SAMPLE, 16'h8000, next_gap());
        send_item(OP_SAMPLE, 16'h7FFF, next_gap());
        write_reg(REG_AVG_COUNT, 16'hFFFF);
        send_item(OP_SAMPLE, 16'h0003, next_gap());
        write_reg(REG_AVG_COUNT, 16'd2);
        send_item(OP_SAMPLE, 16'hFFFE, next_gap());

        // Random captures with fresh settings each time
        items = 0;
        while (items < RANDOM_ITEMS)
        begin
            r = $urandom_range(0, 99);
            if (r < 25)
            begin
                tx_gap_pct   = 0;
                rx_stall_pct = 0;
            end
            else
            begin
                tx_gap_pct   = $urandom_range(10, 40);
                rx_stall_pct = $urandom_range(10, 40);
            end

            r = $urandom_range(0, 99);
            if (r < 10)
                avg = 0;
            else if (r < 55)
                avg = $urandom_range(1, 3);
            else if (r < 90)
                avg = $urandom_range(4, 12);
            else
                avg = $urandom_range(13, 40);
            r = $urandom_range(0, 99);
            if (r < 15)
                limit = 0;
            else if (r < 25)
                limit = 65535;
            else if (r < 65)
                limit = $urandom_range(0, 300);
            else
                limit = $urandom_range(0, 65535);
            r = $urandom_range(0, 99);
            if (r < 20)
                post = 0;
            else if (r < 80)
                post = $urandom_range(1, 12);
            else
                post = $urandom_range(13, 60);
            write_config(SAMPLE_W'(avg), SAMPLE_W'(limit), SAMPLE_W'(post));

            send_item(OP_RESTART, any_value(), next_gap());
            items++;

            base = $urandom_range(0, 65535);
            r = $urandom_range(0, 3);
            spread = (r == 0) ? 0 : (r == 1) ? $urandom_range(0, 64) :
                     (r == 2) ? $urandom_range(0, 2000) : 65535;
            n = $urandom_range(8, 80);
            mid_change = ($urandom_range(0, 99) < 15);

            for (k = 0; k < n; k++)
            begin
                if (tracker.capture_done)
                    break;
                if (mid_change && k == n / 2)
                    write_reg(REG_AVG_COUNT, SAMPLE_W'($urandom_range(0, 6)));
                r = $urandom_range(0, 99);
                if (r < 3)
                    send_item(OP_RESTART, any_value(), next_gap());
                else
                begin
                    if (r < 8)
                        value_in = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                    else if (r < 13)
                        value_in = any_value();
                    else
                        value_in = near_value(base, spread);
                    send_item(OP_SAMPLE, value_in, next_gap());
                end
                items++;
            end

            // a few samples past the end of the capture
            if (tracker.capture_done)
            begin
                r = $urandom_range(0, 2);
                repeat (r) send_item(OP_SAMPLE, any_value(), next_gap());
                items += r;
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (tracker.pending() != 0)
            tracker.report($sformatf("%0d points never came out", tracker.pending()));
        if (tracker.errors == 0)
            $display("** change_triggered_averaged_capture: PASSED **");
        else
            $display("** change_triggered_averaged_capture: FAILED **");
        $finish;
    end

endmodule

// File: sim.f
hdl/cta_pkg.sv
hdl/change_triggered_averaged_capture.sv
tb/sv/tb.sv
